/* hdl/tdfa_pkg.sv */
// package: widths, codes and types shared by the dfa runner files
package tdfa_pkg;

    localparam int NUM_STATES  = 16;
    localparam int SYMBOL_BITS = 8;
    localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
    localparam int TBL_DEPTH   = NUM_STATES * SYM_COUNT;

    localparam int MODE_W    = 2;
    localparam int SYM_W     = 8;
    localparam int STATE_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int SIDX_W = $clog2(NUM_STATES);
    localparam int ADDR_W = SIDX_W + SYMBOL_BITS;

    typedef enum logic [MODE_W-1:0] {
        MODE_WR_TRANS = 2'd0,
        MODE_WR_ALPHA = 2'd1,
        MODE_RUN      = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_REJECTED    = 2'd1,
        ST_UNDEF_INPUT = 2'd2,
        ST_UNDEF_PATH  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STATE = 1'b0,
        CFG_ACCEPTING     = 1'b1
    } t_cfg_idx;

    // one transition table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } t_entry;

    // walk state of the string in progress
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               mismatch;
        logic               path_err;
    } t_walk;

    function automatic logic sym_in_range(input logic [SYM_W-1:0] s);
        return 32'(s) < SYM_COUNT;
    endfunction

    function automatic logic state_in_range(input logic [STATE_W-1:0] s);
        return 32'(s) < NUM_STATES;
    endfunction

endpackage

/* hdl/tdfa_if.sv */
// interfaces: input item channel and result channel of the dfa runner
interface tdfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdfa_pkg::MODE_W-1:0]   mode;
    logic [tdfa_pkg::SYM_W-1:0]    symbol;
    logic [tdfa_pkg::STATE_W-1:0]  source_state;
    logic [tdfa_pkg::STATE_W-1:0]  target_state;
    logic                          entry_valid;
    logic                          last_symbol;

    modport source (output valid, mode, symbol, source_state, target_state, entry_valid,
                    last_symbol, input ready);
    modport sink   (input valid, mode, symbol, source_state, target_state, entry_valid,
                    last_symbol, output ready);
endinterface

interface tdfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [tdfa_pkg::STATUS_W-1:0] status;
    logic [tdfa_pkg::STATE_W-1:0]  final_state;

    modport source (output valid, status, final_state, input ready);
    modport sink   (input valid, status, final_state, output ready);
endinterface

/* hdl/table_driven_dfa_runner.sv */
// top level: table driven dfa recognizer with loadable transition table and alphabet
//
//   channel   dir   handshake          payload
//   i_in      in    valid / ready      mode, symbol, source_state, target_state,
//                                      entry_valid, last_symbol
//   o_out     out   valid / ready      status, final_state
//   i_cfg_*   in    write enable only  index (initial_state, accepting_states), data
//
// one transaction per cycle sustained when nothing stalls. a run transaction reads
// the transition table and alphabet at its accept edge, the walk is resolved in the
// next cycle and the result (last symbol only) is then held in the output register;
// the resolved state of the item in flight feeds the next table address directly
// after reset a clearing pass over NUM_STATES * 2**SYMBOL_BITS (4096) entries empties
// the transition table and alphabet; i_in.ready stays low meanwhile
// a waiting result stalls the walk stage only when that stage also holds a last symbol
module table_driven_dfa_runner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tdfa_in_if.sink                         i_in,
    tdfa_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tdfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tdfa_pkg::CFG_W-1:0]      i_cfg_data
);
    import tdfa_pkg::*;

    // configuration registers
    logic [STATE_W-1:0] r_init;
    logic [CFG_W-1:0]   r_accept;

    // table memories
    t_entry r_tt [TBL_DEPTH];
    logic   r_ab [SYM_COUNT];

    // clearing pass after reset
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_cnt;

    // committed walk state
    t_walk r_walk;
    logic  r_at_start;

    // walk stage: one run transaction with its table read data
    logic   r_s1_valid;
    logic   r_s1_last;
    logic   r_s1_sym_ok;
    logic   r_s1_st_ok;
    t_walk  r_s1_base;
    t_entry r_tt_rd;
    logic   r_ab_rd;

    // output register
    logic               r_o_valid;
    t_status            r_o_status;
    logic [STATE_W-1:0] r_o_final;

    logic                   in_acc;
    logic                   run_acc;
    logic                   trans_wr;
    logic                   alpha_wr;
    logic                   s1_adv;
    logic                   in_sym_ok;
    logic [SYMBOL_BITS-1:0] sym_idx;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    t_walk                  res;
    t_walk                  eff;
    t_walk                  start;
    logic                   eff_start;
    t_status                res_status;

    assign in_acc    = i_in.valid && i_in.ready;
    assign run_acc   = in_acc && (i_in.mode == MODE_RUN);
    assign in_sym_ok = sym_in_range(i_in.symbol);
    assign sym_idx   = i_in.symbol[SYMBOL_BITS-1:0];

    // loads outside the table range are dropped
    assign trans_wr = in_acc && (i_in.mode == MODE_WR_TRANS) && in_sym_ok
                      && state_in_range(i_in.source_state)
                      && state_in_range(i_in.target_state);
    assign alpha_wr = in_acc && (i_in.mode == MODE_WR_ALPHA) && in_sym_ok;
    assign wr_addr  = {i_in.source_state[SIDX_W-1:0], sym_idx};

    // the walk stage stalls only on a last symbol with the output still full
    assign s1_adv     = !r_s1_last || !r_o_valid || o_out.ready;
    assign i_in.ready = !r_clr_active && (!r_s1_valid || s1_adv);

    // resolve one symbol from the table read data
    always_comb begin
        res = r_s1_base;
        if (!r_s1_sym_ok || !r_ab_rd) begin
            // outside the alphabet: stops the string, state frozen
            res.mismatch = 1'b1;
        end else if (!r_s1_base.mismatch && !r_s1_base.path_err) begin
            if (r_s1_st_ok && r_tt_rd.valid) begin
                res.state = r_tt_rd.target;
            end else begin
                res.path_err = 1'b1;
            end
        end
    end

    // mismatch wins over an earlier path error
    always_comb begin
        priority if (res.mismatch) begin
            res_status = ST_UNDEF_INPUT;
        end else if (res.path_err) begin
            res_status = ST_UNDEF_PATH;
        end else if (r_accept[res.state]) begin
            res_status = ST_ACCEPTED;
        end else begin
            res_status = ST_REJECTED;
        end
    end

    // walk state seen by the incoming symbol: bypass from the walk stage
    always_comb begin
        if (r_s1_valid) begin
            eff       = res;
            eff_start = r_s1_last;
        end else begin
            eff       = r_walk;
            eff_start = r_at_start;
        end
        if (eff_start) begin
            start.state    = r_init;
            start.mismatch = 1'b0;
            start.path_err = 1'b0;
        end else begin
            start = eff;
        end
    end

    assign rd_addr = {start.state[SIDX_W-1:0], sym_idx};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_accept <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INITIAL_STATE: r_init   <= i_cfg_data[STATE_W-1:0];
                CFG_ACCEPTING:     r_accept <= i_cfg_data;
            endcase
        end
    end

    // clearing pass sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else if (r_clr_active) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (&r_clr_cnt) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // transition table: clear or load write, run read
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_tt[r_clr_cnt] <= '0;
        end else if (trans_wr) begin
            r_tt[wr_addr] <= i_in.entry_valid ? {1'b1, i_in.target_state} : '0;
        end
        if (run_acc) begin
            r_tt_rd <= r_tt[rd_addr];
        end
    end

    // alphabet map: cleared along with the table sweep
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_ab[r_clr_cnt[SYMBOL_BITS-1:0]] <= 1'b0;
        end else if (alpha_wr) begin
            r_ab[sym_idx] <= i_in.entry_valid;
        end
        if (run_acc) begin
            r_ab_rd <= r_ab[sym_idx];
        end
    end

    // walk stage and committed walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_walk     <= '0;
            r_at_start <= 1'b1;
        end else begin
            if (r_s1_valid && s1_adv) begin
                r_walk     <= res;
                r_at_start <= r_s1_last;
            end
            if (run_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_acc) begin
            r_s1_last   <= i_in.last_symbol;
            r_s1_sym_ok <= in_sym_ok;
            r_s1_st_ok  <= state_in_range(start.state);
            r_s1_base   <= start;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_last && s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_last && s1_adv) begin
            r_o_status <= res_status;
            r_o_final  <= res.state;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.status      = r_o_status;
    assign o_out.final_state = r_o_final;

`ifndef SYNTHESIS
    // no transaction while the tables are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_in.ready)
        else $error("input accepted during clearing pass");

    // an accepted run symbol always occupies the walk stage next cycle
    a_run_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_acc |=> r_s1_valid)
        else $error("run transaction lost before walk stage");

    // a result only appears after a last symbol leaves the walk stage
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_o_valid || o_out.ready) && !(r_s1_valid && r_s1_last) |=> !r_o_valid)
        else $error("result without a last symbol");
`endif

endmodule
